[hdl/ecsm_pkg.sv]
// Shared constants, payload types and modular helpers for the scalar multiplier.
package ecsm_pkg;

	localparam int FIELD_BITS  = 16;
	localparam int SCALAR_BITS = 16;
	localparam int CNT_W       = $clog2(FIELD_BITS + 1);
	localparam int IDX_W       = $clog2(SCALAR_BITS);

	localparam logic CFG_CURVE_A = 1'b0;
	localparam logic CFG_PRIME   = 1'b1;

	typedef logic [FIELD_BITS-1:0] field_t;

	typedef struct packed {
		logic [15:0] point_x;
		logic [15:0] point_y;
		logic [15:0] scalar;
	} ecsm_in_t;

	typedef struct packed {
		logic [15:0] result_x;
		logic [15:0] result_y;
		logic        at_infinity;
	} ecsm_out_t;

	function automatic field_t fadd(input field_t u, input field_t v, input field_t m);
		logic [FIELD_BITS:0] sum;
		sum = {1'b0, u} + {1'b0, v};
		if (sum >= {1'b0, m}) begin
			sum = sum - {1'b0, m};
		end
		return sum[FIELD_BITS-1:0];
	endfunction

	function automatic field_t fsub(input field_t u, input field_t v, input field_t m);
		field_t d;
		d = u - v;
		if (u < v) begin
			d = d + m;
		end
		return d;
	endfunction

endpackage

[hdl/ecsm_mulmod.sv]
// Bit-serial modular multiplier: one multiplier bit per cycle by shift and add.
module ecsm_mulmod import ecsm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  field_t op_a,
	input  field_t op_b,
	input  field_t modulus,
	output field_t product,
	output logic   done
);

	field_t            u_q;
	field_t            v_q;
	field_t            acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(FIELD_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			u_q   <= op_a;
			v_q   <= op_b;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			if (v_q[0]) begin
				acc_q <= fadd(acc_q, u_q, modulus);
			end
			u_q <= fadd(u_q, u_q, modulus);
			v_q <= v_q >> 1;
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

[hdl/ecsm_divider.sv]
// Restoring divider: one quotient bit per cycle, gives quotient and remainder.
module ecsm_divider import ecsm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  field_t dividend,
	input  field_t divisor,
	output field_t quotient,
	output field_t remainder,
	output logic   done
);

	logic [FIELD_BITS:0]   rem_q;
	field_t                quo_q;
	field_t                dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  done_q;
	logic [FIELD_BITS:0]   trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(FIELD_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign trial = {rem_q[FIELD_BITS-1:0], quo_q[FIELD_BITS-1]};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= trial - {1'b0, dvs_q};
				quo_q <= {quo_q[FIELD_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[FIELD_BITS-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q[FIELD_BITS-1:0];
	assign done      = done_q;

endmodule

[hdl/ec_scalar_multiply.sv]
// Top level: elliptic-curve scalar multiplication by double-and-add over a prime field.
//
// The input channel carries a base point and a scalar; the output channel
// returns the scalar multiple with a flag for the point at infinity. Both
// channels use valid and stall, and a transfer happens at a clock edge with
// valid high and stall low. The configuration channel (valid, ready, index,
// data) writes curve_a (index 0) and prime_modulus (index 1); it is always
// ready and is meant to be used only while the block is idle.
// One item is worked on at a time; in_stall is high from acceptance until the
// result is placed in the output register. Every modular product and every
// division holds the sequencer until the unit signals done, and each
// Euclidean step of an inversion runs one division and one product.
// A full doubling runs five products and an inversion, and an addition
// three products and an inversion. A modulus below 3 gives infinity, as
// the sequencer goes straight from acceptance to the result.
// The result register holds while out_stall is high; the next item may be
// accepted meanwhile. Reset clears the sequencer and output valid and sets
// curve_a to 1 and prime_modulus to 11.
module ec_scalar_multiply import ecsm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  ecsm_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output ecsm_out_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_index,
	input  field_t    cfg_data
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_RA   = 5'd1;
	localparam logic [4:0] S_RX   = 5'd2;
	localparam logic [4:0] S_RY   = 5'd3;
	localparam logic [4:0] S_DBL  = 5'd4;
	localparam logic [4:0] S_D1   = 5'd5;
	localparam logic [4:0] S_D2   = 5'd6;
	localparam logic [4:0] S_D3   = 5'd7;
	localparam logic [4:0] S_ADD  = 5'd8;
	localparam logic [4:0] S_A1   = 5'd9;
	localparam logic [4:0] S_F0   = 5'd10;
	localparam logic [4:0] S_F1   = 5'd11;
	localparam logic [4:0] S_F2   = 5'd12;
	localparam logic [4:0] S_F3   = 5'd13;
	localparam logic [4:0] S_F4   = 5'd14;
	localparam logic [4:0] S_NEXT = 5'd15;
	localparam logic [4:0] S_I0   = 5'd16;
	localparam logic [4:0] S_I1   = 5'd17;
	localparam logic [4:0] S_I2   = 5'd18;
	localparam logic [4:0] S_WMUL = 5'd19;
	localparam logic [4:0] S_WDIV = 5'd20;
	localparam logic [4:0] S_FIN  = 5'd21;

	logic [4:0]       state_q;
	logic [4:0]       ret_q;
	logic [4:0]       after_q;
	logic [4:0]       invret_q;
	field_t           a_cfg_q;
	field_t           m_cfg_q;
	field_t           mod_q;
	field_t           a_q;
	field_t           bx_q;
	field_t           by_q;
	logic [SCALAR_BITS-1:0] n_q;
	logic [IDX_W-1:0] idx_q;
	field_t           ax_q;
	field_t           ay_q;
	logic             ainf_q;
	field_t           num_q;
	field_t           k_q;
	field_t           fx1_q;
	field_t           fx2_q;
	field_t           fy1_q;
	field_t           x3_q;
	field_t           r0_q;
	field_t           r1_q;
	field_t           r2_q;
	field_t           t0_q;
	field_t           t1_q;
	logic             ok_q;
	field_t           mul_a_q;
	field_t           mul_b_q;
	logic             mul_go_q;
	field_t           div_n_q;
	field_t           div_d_q;
	logic             div_go_q;
	ecsm_out_t        out_q;
	logic             out_valid_q;

	field_t           prod;
	logic             mul_done;
	field_t           div_quo;
	field_t           div_rem;
	logic             div_done;
	field_t           three_m;

	ecsm_mulmod u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_go_q),
		.op_a    (mul_a_q),
		.op_b    (mul_b_q),
		.modulus (mod_q),
		.product (prod),
		.done    (mul_done)
	);

	ecsm_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go_q),
		.dividend  (div_n_q),
		.divisor   (div_d_q),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	assign three_m   = (mod_q == field_t'(3)) ? '0 : field_t'(3);
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cfg_q <= field_t'(1);
			m_cfg_q <= field_t'(11);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CURVE_A: a_cfg_q <= cfg_data;
				CFG_PRIME:   m_cfg_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			after_q     <= S_IDLE;
			invret_q    <= S_IDLE;
			mul_go_q    <= 1'b0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (m_cfg_q < field_t'(3)) begin
							state_q <= S_FIN;
						end else begin
							div_go_q <= 1'b1;
							ret_q    <= S_RA;
							state_q  <= S_WDIV;
						end
					end
				end
				S_RA: begin
					div_go_q <= 1'b1;
					ret_q    <= S_RX;
					state_q  <= S_WDIV;
				end
				S_RX: begin
					div_go_q <= 1'b1;
					ret_q    <= S_RY;
					state_q  <= S_WDIV;
				end
				S_RY: begin
					after_q <= S_ADD;
					state_q <= S_DBL;
				end
				S_DBL: begin
					if (ainf_q || ay_q == '0) begin
						state_q <= after_q;
					end else begin
						mul_go_q <= 1'b1;
						ret_q    <= S_D1;
						state_q  <= S_WMUL;
					end
				end
				S_D1: begin
					mul_go_q <= 1'b1;
					ret_q    <= S_D2;
					state_q  <= S_WMUL;
				end
				S_D2: begin
					invret_q <= S_D3;
					state_q  <= S_I0;
				end
				S_D3: begin
					if (!ok_q) begin
						state_q <= after_q;
					end else begin
						mul_go_q <= 1'b1;
						ret_q    <= S_F0;
						state_q  <= S_WMUL;
					end
				end
				S_ADD: begin
					if (!n_q[idx_q] || ainf_q) begin
						state_q <= S_NEXT;
					end else if (ax_q == bx_q) begin
						after_q <= S_NEXT;
						state_q <= (ay_q == by_q) ? S_DBL : S_NEXT;
					end else begin
						after_q  <= S_NEXT;
						invret_q <= S_A1;
						state_q  <= S_I0;
					end
				end
				S_A1: begin
					if (!ok_q) begin
						state_q <= after_q;
					end else begin
						mul_go_q <= 1'b1;
						ret_q    <= S_F0;
						state_q  <= S_WMUL;
					end
				end
				S_F0: begin
					mul_go_q <= 1'b1;
					ret_q    <= S_F1;
					state_q  <= S_WMUL;
				end
				S_F1: state_q <= S_F2;
				S_F2: begin
					mul_go_q <= 1'b1;
					ret_q    <= S_F4;
					state_q  <= S_WMUL;
				end
				S_F3: state_q <= S_F4;
				S_F4: state_q <= after_q;
				S_NEXT: begin
					if (idx_q == '0) begin
						state_q <= S_FIN;
					end else begin
						after_q <= S_ADD;
						state_q <= S_DBL;
					end
				end
				S_I0: begin
					if (r1_q == '0) begin
						state_q <= invret_q;
					end else begin
						div_go_q <= 1'b1;
						ret_q    <= S_I1;
						state_q  <= S_WDIV;
					end
				end
				S_I1: begin
					mul_go_q <= 1'b1;
					ret_q    <= S_I2;
					state_q  <= S_WMUL;
				end
				S_I2: state_q <= S_I0;
				S_WMUL: begin
					if (mul_done) begin
						state_q <= ret_q;
					end
				end
				S_WDIV: begin
					if (div_done) begin
						state_q <= ret_q;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				mod_q   <= m_cfg_q;
				bx_q    <= in_data.point_x;
				by_q    <= in_data.point_y;
				n_q     <= in_data.scalar[SCALAR_BITS-1:0];
				ainf_q  <= 1'b1;
				ax_q    <= '0;
				ay_q    <= '0;
				idx_q   <= IDX_W'(SCALAR_BITS - 1);
				div_n_q <= a_cfg_q;
				div_d_q <= m_cfg_q;
			end
			S_RA: begin
				a_q     <= div_rem;
				div_n_q <= bx_q;
			end
			S_RX: begin
				bx_q    <= div_rem;
				div_n_q <= by_q;
			end
			S_RY: by_q <= div_rem;
			S_DBL: begin
				if (ainf_q || ay_q == '0) begin
					ainf_q <= 1'b1;
				end
				mul_a_q <= ax_q;
				mul_b_q <= ax_q;
			end
			S_D1: begin
				mul_a_q <= three_m;
				mul_b_q <= prod;
			end
			S_D2: begin
				num_q <= fadd(prod, a_q, mod_q);
				r0_q  <= mod_q;
				r1_q  <= fadd(ay_q, ay_q, mod_q);
				t0_q  <= '0;
				t1_q  <= field_t'(1);
				fx1_q <= ax_q;
				fx2_q <= ax_q;
				fy1_q <= ay_q;
			end
			S_D3: begin
				if (!ok_q) begin
					ainf_q <= 1'b1;
				end
				mul_a_q <= num_q;
				mul_b_q <= t0_q;
			end
			S_ADD: begin
				if (n_q[idx_q]) begin
					if (ainf_q) begin
						ax_q   <= bx_q;
						ay_q   <= by_q;
						ainf_q <= 1'b0;
					end else if (ax_q == bx_q) begin
						if (ay_q != by_q) begin
							ainf_q <= 1'b1;
						end
					end else begin
						r0_q  <= mod_q;
						r1_q  <= fsub(bx_q, ax_q, mod_q);
						t0_q  <= '0;
						t1_q  <= field_t'(1);
						fx1_q <= ax_q;
						fx2_q <= bx_q;
						fy1_q <= ay_q;
						num_q <= fsub(by_q, ay_q, mod_q);
					end
				end
			end
			S_A1: begin
				if (!ok_q) begin
					ainf_q <= 1'b1;
				end
				mul_a_q <= num_q;
				mul_b_q <= t0_q;
			end
			S_F0: begin
				k_q     <= prod;
				mul_a_q <= prod;
				mul_b_q <= prod;
			end
			S_F1: x3_q <= fsub(prod, fx1_q, mod_q);
			S_F2: begin
				mul_a_q <= k_q;
				mul_b_q <= fsub(fx1_q, fsub(x3_q, fx2_q, mod_q), mod_q);
				x3_q    <= fsub(x3_q, fx2_q, mod_q);
			end
			S_F3: x3_q <= x3_q;
			S_F4: begin
				ax_q   <= x3_q;
				ay_q   <= fsub(prod, fy1_q, mod_q);
				ainf_q <= 1'b0;
			end
			S_NEXT: begin
				if (idx_q != '0) begin
					idx_q <= idx_q - 1'b1;
				end
			end
			S_I0: begin
				ok_q    <= (r0_q == field_t'(1));
				div_n_q <= r0_q;
				div_d_q <= r1_q;
			end
			S_I1: begin
				r2_q    <= div_rem;
				mul_a_q <= (div_quo >= mod_q) ? (div_quo - mod_q) : div_quo;
				mul_b_q <= t1_q;
			end
			S_I2: begin
				t1_q <= fsub(t0_q, prod, mod_q);
				t0_q <= t1_q;
				r0_q <= r1_q;
				r1_q <= r2_q;
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_q.at_infinity <= ainf_q;
					out_q.result_x    <= ainf_q ? '0 : ax_q;
					out_q.result_y    <= ainf_q ? '0 : ay_q;
				end
			end
			default: ;
		endcase
	end

endmodule

[tb/ec_scalar_multiply_test.sv]
// Testbench for the elliptic-curve scalar multiplier with its own predictor and checker.
`timescale 1ns / 100ps

module ec_scalar_multiply_test;
	import ecsm_pkg::*;

	typedef struct {
		longint unsigned x;
		longint unsigned y;
		bit              inf;
	} curve_pt_t;

	localparam longint CYCLE_LIMIT = 40_000_000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	ecsm_in_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	ecsm_out_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_index = CFG_CURVE_A;
	field_t    cfg_data = '0;

	ecsm_out_t       expected_products[$];
	longint unsigned coeff_a = 1;
	longint unsigned modulus = 11;
	int              errors = 0;
	int              send_idle_pct = 0;
	int              stall_pct = 0;
	bit              hold_output = 1'b0;
	longint          cycles = 0;

	ec_scalar_multiply DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic bit field_inverse(longint unsigned v, longint unsigned m,
			output longint unsigned inv);
		longint r0 = m, r1 = v, t0 = 0, t1 = 1, q, tmp;
		while (r1 != 0) begin
			q = r0 / r1;
			tmp = r0 - q * r1; r0 = r1; r1 = tmp;
			tmp = t0 - q * t1; t0 = t1; t1 = tmp;
		end
		inv = ((t0 % longint'(m)) + longint'(m)) % longint'(m);
		return r0 == 1;
	endfunction

	function automatic curve_pt_t chord_point(longint unsigned k, longint unsigned x1,
			longint unsigned y1, longint unsigned x2, longint unsigned m);
		curve_pt_t r;
		r.inf = 1'b0;
		r.x = ((k * k) % m + 2 * m - x1 - x2) % m;
		r.y = ((k * ((x1 + m - r.x) % m)) % m + m - y1) % m;
		return r;
	endfunction

	function automatic curve_pt_t point_double(curve_pt_t s, longint unsigned a,
			longint unsigned m);
		curve_pt_t inf_pt = '{0, 0, 1'b1};
		longint unsigned num, den, iv;
		if (s.inf || s.y == 0) return inf_pt;
		num = (3 * ((s.x * s.x) % m) + a) % m;
		den = (2 * s.y) % m;
		if (!field_inverse(den, m, iv)) return inf_pt;
		return chord_point((num * iv) % m, s.x, s.y, s.x, m);
	endfunction

	function automatic curve_pt_t point_add(curve_pt_t s, curve_pt_t t, longint unsigned a,
			longint unsigned m);
		curve_pt_t inf_pt = '{0, 0, 1'b1};
		longint unsigned iv;
		if (s.inf) return t;
		if (t.inf) return s;
		if (s.x == t.x) return (s.y == t.y) ? point_double(s, a, m) : inf_pt;
		if (!field_inverse((t.x + m - s.x) % m, m, iv)) return inf_pt;
		return chord_point((((t.y + m - s.y) % m) * iv) % m, s.x, s.y, t.x, m);
	endfunction

	function automatic ecsm_out_t scalar_multiple(ecsm_in_t item);
		curve_pt_t acc = '{0, 0, 1'b1};
		curve_pt_t base;
		ecsm_out_t r;
		longint unsigned m = modulus, a;
		if (m >= 3) begin
			a = coeff_a % m;
			base = '{item.point_x % m, item.point_y % m, 1'b0};
			for (int i = SCALAR_BITS - 1; i >= 0; i--) begin
				acc = point_double(acc, a, m);
				if (item.scalar[i]) acc = point_add(acc, base, a, m);
			end
		end
		r.at_infinity = acc.inf;
		r.result_x = acc.inf ? 16'd0 : 16'(acc.x);
		r.result_y = acc.inf ? 16'd0 : 16'(acc.y);
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) out_stall <= hold_output || ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		ecsm_out_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_products.size() == 0) begin
				$error("unexpected result transfer x=%0d y=%0d inf=%0d",
					out_data.result_x, out_data.result_y, out_data.at_infinity);
				errors++;
			end else begin
				exp_r = expected_products.pop_front();
				if (out_data.result_x !== exp_r.result_x) begin
					$error("result_x expected %0d actual %0d", exp_r.result_x, out_data.result_x);
					errors++;
				end
				if (out_data.result_y !== exp_r.result_y) begin
					$error("result_y expected %0d actual %0d", exp_r.result_y, out_data.result_y);
					errors++;
				end
				if (out_data.at_infinity !== exp_r.at_infinity) begin
					$error("at_infinity expected %0d actual %0d", exp_r.at_infinity,
						out_data.at_infinity);
					errors++;
				end
			end
		end
	end

	// Called and returns just after a falling edge.
	task automatic write_reg(logic idx, field_t value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_CURVE_A) coeff_a = value;
		else modulus = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_point(field_t x, field_t y, logic [15:0] n);
		ecsm_in_t item;
		item.point_x = x;
		item.point_y = y;
		item.scalar = n;
		in_data = item;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		expected_products.push_back(scalar_multiple(item));
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	endtask

	task automatic drain;
		in_valid = 1'b0;
		while (expected_products.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_point;
		field_t x, y;
		if ($urandom_range(3) == 0) begin
			x = field_t'($urandom);
			y = field_t'($urandom);
		end else begin
			x = field_t'($urandom_range(modulus > 0 ? modulus - 1 : 0));
			y = field_t'($urandom_range(modulus > 0 ? modulus - 1 : 0));
		end
		send_point(x, y, $urandom_range(7) == 0 ? 16'($urandom_range(15)) : 16'($urandom));
	endtask

	task automatic test_reset_values;
		send_point(0, 0, 0);
		send_point(2, 7, 1);
		send_point(2, 7, 2);
		send_point(5, 0, 2);
		send_point(5, 0, 1);
		send_point(16'hffff, 16'hffff, 16'hffff);
		send_point(3, 4, 16'h8000);
		send_point(9, 1, 13);
		drain();
	endtask

	task automatic test_register_extremes;
		write_reg(CFG_CURVE_A, 16'd0);
		write_reg(CFG_PRIME, 16'd65521);
		send_point(1, 2, 16'hffff);
		send_point(65520, 65520, 3);
		drain();
		write_reg(CFG_CURVE_A, 16'hffff);
		write_reg(CFG_PRIME, 16'd3);
		send_point(1, 1, 2);
		send_point(2, 0, 5);
		drain();
		write_reg(CFG_PRIME, 16'hffff);
		send_point(16'h1234, 16'h4321, 16'h00ff);
		drain();
		write_reg(CFG_CURVE_A, 16'd3);
		write_reg(CFG_PRIME, 16'd15);
		send_point(4, 6, 9);
		send_point(3, 5, 7);
		drain();
	endtask

	task automatic test_degenerate_moduli;
		write_reg(CFG_PRIME, 16'd0);
		send_point(1, 1, 1);
		drain();
		write_reg(CFG_PRIME, 16'd1);
		send_point(0, 0, 16'hffff);
		drain();
		write_reg(CFG_PRIME, 16'd2);
		send_point(1, 1, 3);
		drain();
	endtask

	task automatic test_random_sweep;
		int primes[] = '{5, 7, 11, 13, 17, 23, 31, 97, 101, 251, 257, 1009, 7919, 65521};
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 56; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 56; end
				default: begin send_idle_pct = 24; stall_pct = 24; end
			endcase
			write_reg(CFG_CURVE_A, field_t'($urandom));
			if (phase == 7) write_reg(CFG_PRIME, field_t'($urandom));
			else write_reg(CFG_PRIME, field_t'(primes[$urandom_range(phase < 6 ? 9 : 13)]));
			repeat (36) send_random_point();
			drain();
		end
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_backpressure;
		write_reg(CFG_CURVE_A, 16'd2);
		write_reg(CFG_PRIME, 16'd17);
		fork
			begin
				hold_output = 1'b1;
				repeat (30000) @(posedge clk);
				hold_output = 1'b0;
			end
		join_none
		repeat (5) send_random_point();
		drain();
		repeat (3) send_random_point();
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_values();
		test_register_extremes();
		test_degenerate_moduli();
		test_random_sweep();
		test_backpressure();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
